// File: rtl/core/mib_enc_pkg.sv
// Package with the item types, codes and encoding functions of the entry encoder.
`default_nettype none

package mib_enc_pkg;

    localparam int MAX_INDEXES = 2;
    localparam int MAX_OCTETS  = 1024;

    localparam logic [2:0] KIND_NONE     = 3'd0;
    localparam logic [2:0] KIND_UNSIGNED = 3'd1;
    localparam logic [2:0] KIND_SIGNED   = 3'd2;
    localparam logic [2:0] KIND_OCTETS   = 3'd3;
    localparam logic [2:0] KIND_BOOLEAN  = 3'd4;

    localparam logic       ACTION_HEADER  = 1'b0;
    localparam logic       ACTION_PAYLOAD = 1'b1;

    localparam logic [7:0]  UINT_HDR    = 8'h80;
    localparam logic [7:0]  SINT_HDR    = 8'hC0;
    localparam logic [7:0]  OCT_SHORT   = 8'hA1;
    localparam logic [7:0]  OCT_LONG    = 8'hA2;
    localparam logic [7:0]  PAD_BYTE    = 8'h00;
    localparam logic [31:0] SHORT_LIMIT = 32'd64;
    localparam logic [31:0] SMALL_NEG   = 32'hFFFF_FFC0;

    typedef struct packed {
        logic        action;
        logic [15:0] param_id;
        logic [15:0] index_a;
        logic [15:0] index_b;
        logic [2:0]  value_kind;
        logic [31:0] value_word;
        logic [10:0] octet_count;
        logic [7:0]  payload_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
        logic       bad_kind;
    } out_item_t;

    // Up to five bytes of one encoded field, first byte in the top bits.
    typedef struct packed {
        logic [39:0] bytes;
        logic [2:0]  len;
    } seg_t;

    // Header item after encoding, as held in the input register.
    typedef struct packed {
        logic        is_payload;
        logic        bad;
        logic [15:0] param_id;
        logic [15:0] len_field;
        seg_t        seg_a;
        seg_t        seg_b;
        seg_t        seg_v;
        logic [3:0]  off_b;
        logic [3:0]  off_v;
        logic [3:0]  off_end;
        logic [10:0] count;
        logic        odd;
        logic [7:0]  payload_byte;
    } prep_t;

    function automatic seg_t enc_uint(logic [31:0] v);
        seg_t s;
        s.bytes = '0;
        s.len   = 3'd1;
        if (v < SHORT_LIMIT)
        begin
            s.bytes[39:32] = v[7:0];
        end
        else if (v[31:24] != 8'h00)
        begin
            s.bytes = {UINT_HDR | 8'd4, v};
            s.len   = 3'd5;
        end
        else if (v[23:16] != 8'h00)
        begin
            s.bytes = {UINT_HDR | 8'd3, v[23:0], 8'h00};
            s.len   = 3'd4;
        end
        else if (v[15:8] != 8'h00)
        begin
            s.bytes = {UINT_HDR | 8'd2, v[15:0], 16'h0000};
            s.len   = 3'd3;
        end
        else
        begin
            s.bytes = {UINT_HDR | 8'd1, v[7:0], 24'h000000};
            s.len   = 3'd2;
        end
        return s;
    endfunction

    function automatic seg_t enc_int(logic [31:0] v);
        seg_t s;
        logic d1;
        logic d2;
        logic d3;
        s.bytes = '0;
        s.len   = 3'd1;
        // A leading 0xFF byte is dropped while the next byte keeps the sign.
        d1 = (v[31:24] == 8'hFF) && v[23];
        d2 = d1 && (v[23:16] == 8'hFF) && v[15];
        d3 = d2 && (v[15:8] == 8'hFF) && v[7];
        if (!v[31])
        begin
            s = enc_uint(v);
        end
        else if (v >= SMALL_NEG)
        begin
            s.bytes[39:32] = {1'b0, v[6:0]};
        end
        else if (d3)
        begin
            s.bytes = {SINT_HDR | 8'd1, v[7:0], 24'h000000};
            s.len   = 3'd2;
        end
        else if (d2)
        begin
            s.bytes = {SINT_HDR | 8'd2, v[15:0], 16'h0000};
            s.len   = 3'd3;
        end
        else if (d1)
        begin
            s.bytes = {SINT_HDR | 8'd3, v[23:0], 8'h00};
            s.len   = 3'd4;
        end
        else
        begin
            s.bytes = {SINT_HDR | 8'd4, v};
            s.len   = 3'd5;
        end
        return s;
    endfunction

    function automatic logic [7:0] seg_byte(seg_t s, logic [2:0] k);
        logic [7:0] b;
        case (k)
            3'd0:    b = s.bytes[39:32];
            3'd1:    b = s.bytes[31:24];
            3'd2:    b = s.bytes[23:16];
            3'd3:    b = s.bytes[15:8];
            default: b = s.bytes[7:0];
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/mib_entry_encoder_top.sv
// Top level of the parameter entry encoder: input register, byte sequencing and result register.
//
// Items arrive on the item channel (item, item_valid, item_stall) and encoded bytes
// leave on the result channel (result, res_valid, res_stall), one byte per transfer.
// A header item (action 0) is encoded as it is taken into the input register and then
// yields its bytes, 4 to 16 of them, one per cycle while res_stall is low: id, length,
// indexes, value and pad. An octet-string header gives as its value only the length
// prefix; the data bytes come from the payload items (action 1) that follow, each
// giving one byte, and the last one also the pad when the entry is odd. An invalid
// kind gives a single result with bad_kind set. The first byte of an item passes from
// the input register into the result register once that register is free. Payload
// items flow at one per cycle while res_stall is low; a header holds the input register
// until its last byte is passed on and keeps item_stall high until then, and the next
// item is taken in at the same edge as the last byte. A payload item with no octet
// still due is dropped with no result. When res_stall is high the result register
// holds its byte and the sequencing waits. Reset clears both valid flags, the
// position counter and the payload state; no entry is in progress after reset.
`default_nettype none

module mib_entry_encoder_top (
    input  var logic                   clk,
    input  var logic                   rst_n,
    input  var mib_enc_pkg::in_item_t  item,
    input  var logic                   item_valid,
    output var logic                   item_stall,
    output var mib_enc_pkg::out_item_t result,
    output var logic                   res_valid,
    input  var logic                   res_stall
);

    mib_enc_pkg::prep_t     prep_next;
    mib_enc_pkg::prep_t     prep_reg;
    logic                   item_valid_reg;
    logic [3:0]             pos_reg;
    logic [10:0]            payload_left_reg;
    logic                   pad_due_reg;
    mib_enc_pkg::out_item_t res_next;
    mib_enc_pkg::out_item_t res_reg;
    logic                   res_valid_reg;

    logic [4:0]             res_count;
    logic [10:0]            payload_left_next;
    logic                   pad_due_next;
    logic                   fire;
    logic                   done;
    logic                   accept;

    mib_enc_format u_format (
        .item (item),
        .prep (prep_next)
    );

    mib_enc_emit u_emit (
        .prep              (prep_reg),
        .payload_left      (payload_left_reg),
        .pad_due           (pad_due_reg),
        .pos               (pos_reg),
        .res               (res_next),
        .res_count         (res_count),
        .payload_left_next (payload_left_next),
        .pad_due_next      (pad_due_next)
    );

    assign fire = item_valid_reg && ({1'b0, pos_reg} < res_count)
                  && (!res_valid_reg || !res_stall);
    assign done = item_valid_reg
                  && ((res_count == 5'd0) || (fire && ({1'b0, pos_reg} + 5'd1 == res_count)));
    assign item_stall = item_valid_reg && !done;
    assign accept     = item_valid && !item_stall;

    assign result    = res_reg;
    assign res_valid = res_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            pos_reg          <= 4'd0;
            payload_left_reg <= 11'd0;
            pad_due_reg      <= 1'b0;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (done)
            begin
                item_valid_reg <= 1'b0;
            end

            if (done)
            begin
                pos_reg          <= 4'd0;
                payload_left_reg <= payload_left_next;
                pad_due_reg      <= pad_due_next;
            end
            else if (fire)
            begin
                pos_reg <= pos_reg + 4'd1;
            end

            res_valid_reg <= fire || (res_valid_reg && res_stall);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prep_reg <= prep_next;
        end
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/mib_enc_format.sv
// Encodes the fields of an incoming header item into byte segments and offsets.
`default_nettype none

module mib_enc_format (
    input  var mib_enc_pkg::in_item_t item,
    output var mib_enc_pkg::prep_t    prep
);

    mib_enc_pkg::seg_t seg_a;
    mib_enc_pkg::seg_t seg_b;
    mib_enc_pkg::seg_t seg_v;
    logic              use_a;
    logic              use_b;
    logic [10:0]       count;
    logic [3:0]        off_b;
    logic [3:0]        off_v;
    logic [3:0]        off_end;
    logic [11:0]       total;
    logic              bad;

    assign bad   = (item.value_kind > mib_enc_pkg::KIND_BOOLEAN);
    assign use_a = (mib_enc_pkg::MAX_INDEXES >= 1) && (item.index_a != 16'd0);
    assign use_b = (mib_enc_pkg::MAX_INDEXES >= 2) && use_a && (item.index_b != 16'd0);

    always_comb
    begin
        seg_a = mib_enc_pkg::enc_uint({16'd0, item.index_a});
        seg_b = mib_enc_pkg::enc_uint({16'd0, item.index_b});
        if (!use_a)
        begin
            seg_a.len = 3'd0;
        end
        if (!use_b)
        begin
            seg_b.len = 3'd0;
        end
    end

    always_comb
    begin
        seg_v = '0;
        count = 11'd0;
        case (item.value_kind)
            mib_enc_pkg::KIND_UNSIGNED: seg_v = mib_enc_pkg::enc_uint(item.value_word);
            mib_enc_pkg::KIND_SIGNED:   seg_v = mib_enc_pkg::enc_int(item.value_word);
            mib_enc_pkg::KIND_BOOLEAN:
            begin
                seg_v = mib_enc_pkg::enc_uint({31'd0, item.value_word != 32'd0});
            end
            mib_enc_pkg::KIND_OCTETS:
            begin
                if (int'(item.octet_count) > mib_enc_pkg::MAX_OCTETS)
                begin
                    count = 11'(mib_enc_pkg::MAX_OCTETS);
                end
                else
                begin
                    count = item.octet_count;
                end
                if (count > 11'd255)
                begin
                    seg_v.bytes = {mib_enc_pkg::OCT_LONG, 5'd0, count, 16'd0};
                    seg_v.len   = 3'd3;
                end
                else
                begin
                    seg_v.bytes = {mib_enc_pkg::OCT_SHORT, count[7:0], 24'd0};
                    seg_v.len   = 3'd2;
                end
            end
            default:    seg_v = '0;
        endcase
    end

    assign off_b   = 4'd4 + {1'b0, seg_a.len};
    assign off_v   = off_b + {1'b0, seg_b.len};
    assign off_end = off_v + {1'b0, seg_v.len};
    assign total   = {8'd0, off_end} + {1'b0, count};

    always_comb
    begin
        prep.is_payload   = (item.action == mib_enc_pkg::ACTION_PAYLOAD);
        prep.bad          = bad;
        prep.param_id     = item.param_id;
        prep.len_field    = {4'd0, total} - 16'd4;
        prep.seg_a        = seg_a;
        prep.seg_b        = seg_b;
        prep.seg_v        = seg_v;
        prep.off_b        = off_b;
        prep.off_v        = off_v;
        prep.off_end      = off_end;
        prep.count        = count;
        prep.odd          = total[0];
        prep.payload_byte = item.payload_byte;
    end

endmodule

`default_nettype wire

// File: rtl/core/mib_enc_emit.sv
// Picks the result at one position of the held item and works out the next stream state.
`default_nettype none

module mib_enc_emit (
    input  var mib_enc_pkg::prep_t     prep,
    input  var logic [10:0]            payload_left,
    input  var logic                   pad_due,
    input  var logic [3:0]             pos,
    output var mib_enc_pkg::out_item_t res,
    output var logic [4:0]             res_count,
    output var logic [10:0]            payload_left_next,
    output var logic                   pad_due_next
);

    logic [10:0] left_dec;
    logic        hdr_pad;
    logic [4:0]  hdr_count;
    logic [7:0]  hdr_byte;

    assign left_dec  = payload_left - 11'd1;
    // A header with no octet payload closes the entry itself, pad included.
    assign hdr_pad   = (prep.count == 11'd0) && prep.odd;
    assign hdr_count = {1'b0, prep.off_end} + {4'd0, hdr_pad};

    always_comb
    begin
        if (pos == 4'd0)
        begin
            hdr_byte = prep.param_id[7:0];
        end
        else if (pos == 4'd1)
        begin
            hdr_byte = prep.param_id[15:8];
        end
        else if (pos == 4'd2)
        begin
            hdr_byte = prep.len_field[7:0];
        end
        else if (pos == 4'd3)
        begin
            hdr_byte = prep.len_field[15:8];
        end
        else if (pos < prep.off_b)
        begin
            hdr_byte = mib_enc_pkg::seg_byte(prep.seg_a, 3'(pos - 4'd4));
        end
        else if (pos < prep.off_v)
        begin
            hdr_byte = mib_enc_pkg::seg_byte(prep.seg_b, 3'(pos - prep.off_b));
        end
        else if (pos < prep.off_end)
        begin
            hdr_byte = mib_enc_pkg::seg_byte(prep.seg_v, 3'(pos - prep.off_v));
        end
        else
        begin
            hdr_byte = mib_enc_pkg::PAD_BYTE;
        end
    end

    always_comb
    begin
        res               = '0;
        res_count         = 5'd0;
        payload_left_next = 11'd0;
        pad_due_next      = 1'b0;
        if (prep.is_payload)
        begin
            if (payload_left == 11'd0)
            begin
                pad_due_next = pad_due;
            end
            else
            begin
                payload_left_next = left_dec;
                pad_due_next      = (left_dec != 11'd0) && pad_due;
                res_count         = ((left_dec == 11'd0) && pad_due) ? 5'd2 : 5'd1;
                if (pos == 4'd0)
                begin
                    res.out_byte  = prep.payload_byte;
                    res.last_byte = (left_dec == 11'd0) && !pad_due;
                end
                else
                begin
                    res.out_byte  = mib_enc_pkg::PAD_BYTE;
                    res.last_byte = 1'b1;
                end
            end
        end
        else if (prep.bad)
        begin
            res_count    = 5'd1;
            res.bad_kind = 1'b1;
        end
        else
        begin
            res_count         = hdr_count;
            res.out_byte      = hdr_byte;
            res.last_byte     = (prep.count == 11'd0) && ({1'b0, pos} + 5'd1 == hdr_count);
            payload_left_next = prep.count;
            pad_due_next      = (prep.count != 11'd0) && prep.odd;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/mib_enc_checker.sv
// Port-level checks on the entry encoder and the bind that attaches them.
`default_nettype none

module mib_enc_checker (
    input var logic                   clk,
    input var logic                   rst_n,
    input var logic                   item_stall,
    input var mib_enc_pkg::out_item_t result,
    input var logic                   res_valid,
    input var logic                   res_stall
);

    // A stalled result transfer keeps its byte.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(result))
        else $error("result changed while stalled");

    // An error result carries no byte and does not close an entry.
    a_bad_clean: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && result.bad_kind |-> result.out_byte == 8'h00 && !result.last_byte)
        else $error("bad kind result carries data");

    // Holding the input with an empty result register must produce a byte next.
    a_progress: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid && item_stall |=> res_valid)
        else $error("input held without producing a result");

    // A clock edge in reset leaves nothing offered and nothing held.
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !res_valid && !item_stall)
        else $error("activity during reset");

endmodule

bind mib_entry_encoder_top mib_enc_checker u_mib_enc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_stall (item_stall),
    .result     (result),
    .res_valid  (res_valid),
    .res_stall  (res_stall)
);

`default_nettype wire

// File: sim/mib_entry_encoder_top_tb.sv
// Self-checking testbench for the parameter entry encoder: random and directed entries.
module mib_entry_encoder_top_tb;

    localparam logic [2:0] KIND_BAD_FIRST = 3'd5;
    localparam logic [2:0] KIND_BAD_MID   = 3'd6;
    localparam logic [2:0] KIND_BAD_LAST  = 3'd7;
    localparam int RANDOM_ITEMS = 244;
    localparam int PHASE_ITEMS  = 40;
    localparam int DRAIN_CYCLES = 40;
    localparam int QUIET_LIMIT  = 2000;
    localparam int REPORT_LIMIT = 10;

    // Expected byte stream of the encoder and the running comparison against it.
    class entry_scoreboard;
        mib_enc_pkg::out_item_t byte_queue[$];
        logic [7:0]             entry_bytes[$];
        logic [10:0]            octets_left;
        bit                     pad_pending;
        int                     errors;

        function new();
            octets_left = '0;
            pad_pending = 1'b0;
            errors      = 0;
        endfunction

        function int pending();
            return byte_queue.size();
        endfunction

        function void queue_byte(logic [7:0] b, logic last, logic bad);
            mib_enc_pkg::out_item_t r;
            r.out_byte  = b;
            r.last_byte = last;
            r.bad_kind  = bad;
            byte_queue.push_back(r);
        endfunction

        function void put_unsigned(logic [31:0] v);
            int n;
            if (v < 32'd64)
            begin
                entry_bytes.push_back(v[7:0]);
                return;
            end
            n = 4;
            while (v[8*n-1 -: 8] == 8'h00)
                n--;
            entry_bytes.push_back(mib_enc_pkg::UINT_HDR | 8'(n));
            for (int i = n; i >= 1; i--)
                entry_bytes.push_back(v[8*i-1 -: 8]);
        endfunction

        function void put_signed(logic [31:0] v);
            int n;
            if (!v[31])
            begin
                put_unsigned(v);
                return;
            end
            if (v >= 32'hFFFF_FFC0)
            begin
                entry_bytes.push_back({1'b0, v[6:0]});
                return;
            end
            // Leading 0xFF bytes go while the byte below still carries the sign.
            n = 4;
            while (n > 1 && v[8*n-1 -: 8] == 8'hFF && v[8*n-9])
                n--;
            entry_bytes.push_back(mib_enc_pkg::SINT_HDR | 8'(n));
            for (int i = n; i >= 1; i--)
                entry_bytes.push_back(v[8*i-1 -: 8]);
        endfunction

        function void note_item(mib_enc_pkg::in_item_t it);
            logic [15:0] cnt;
            logic [15:0] len_field;
            int          total;
            int          n_idx;
            bit          odd;
            if (it.action == mib_enc_pkg::ACTION_PAYLOAD)
            begin
                if (octets_left == 0)
                    return;
                octets_left--;
                if (octets_left != 0)
                    queue_byte(it.payload_byte, 1'b0, 1'b0);
                else if (pad_pending)
                begin
                    pad_pending = 1'b0;
                    queue_byte(it.payload_byte, 1'b0, 1'b0);
                    queue_byte(mib_enc_pkg::PAD_BYTE, 1'b1, 1'b0);
                end
                else
                    queue_byte(it.payload_byte, 1'b1, 1'b0);
                return;
            end

            // A new header drops whatever octet string was still open.
            octets_left = '0;
            pad_pending = 1'b0;
            if (it.value_kind > mib_enc_pkg::KIND_BOOLEAN)
            begin
                queue_byte(8'h00, 1'b0, 1'b1);
                return;
            end
            entry_bytes.delete();
            entry_bytes.push_back(it.param_id[7:0]);
            entry_bytes.push_back(it.param_id[15:8]);
            entry_bytes.push_back(8'h00);
            entry_bytes.push_back(8'h00);
            n_idx = mib_enc_pkg::MAX_INDEXES < 2 ? mib_enc_pkg::MAX_INDEXES : 2;
            if (n_idx >= 1 && it.index_a != 0)
            begin
                put_unsigned({16'h0000, it.index_a});
                if (n_idx >= 2 && it.index_b != 0)
                    put_unsigned({16'h0000, it.index_b});
            end
            cnt = '0;
            case (it.value_kind)
                mib_enc_pkg::KIND_UNSIGNED: put_unsigned(it.value_word);
                mib_enc_pkg::KIND_SIGNED:   put_signed(it.value_word);
                mib_enc_pkg::KIND_BOOLEAN:  put_unsigned(it.value_word != 0 ? 32'd1 : 32'd0);
                mib_enc_pkg::KIND_OCTETS:
                begin
                    cnt = (it.octet_count > mib_enc_pkg::MAX_OCTETS)
                          ? 16'(mib_enc_pkg::MAX_OCTETS) : {5'b0, it.octet_count};
                    if (cnt > 16'd255)
                    begin
                        entry_bytes.push_back(mib_enc_pkg::OCT_LONG);
                        entry_bytes.push_back(cnt[15:8]);
                        entry_bytes.push_back(cnt[7:0]);
                    end
                    else
                    begin
                        entry_bytes.push_back(mib_enc_pkg::OCT_SHORT);
                        entry_bytes.push_back(cnt[7:0]);
                    end
                end
                default: ;
            endcase
            total          = entry_bytes.size() + int'(cnt);
            len_field      = 16'(total - 4);
            entry_bytes[2] = len_field[7:0];
            entry_bytes[3] = len_field[15:8];
            odd            = total[0];
            foreach (entry_bytes[k])
                queue_byte(entry_bytes[k],
                           k == entry_bytes.size() - 1 && cnt == 0 && !odd, 1'b0);
            if (cnt != 0)
            begin
                octets_left = cnt[10:0];
                pad_pending = odd;
            end
            else if (odd)
                queue_byte(mib_enc_pkg::PAD_BYTE, 1'b1, 1'b0);
        endfunction

        function void check_result(mib_enc_pkg::out_item_t got);
            mib_enc_pkg::out_item_t want;
            if (byte_queue.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("unexpected transfer: byte %02h last %0b bad %0b",
                             got.out_byte, got.last_byte, got.bad_kind);
                return;
            end
            want = byte_queue.pop_front();
            if (got.out_byte !== want.out_byte || got.last_byte !== want.last_byte ||
                got.bad_kind !== want.bad_kind)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display({"mismatch: expected byte %02h last %0b bad %0b, ",
                              "got byte %02h last %0b bad %0b"},
                             want.out_byte, want.last_byte, want.bad_kind,
                             got.out_byte, got.last_byte, got.bad_kind);
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    mib_enc_pkg::in_item_t  item = '0;
    logic                   item_valid = 1'b0;
    logic                   item_stall;
    mib_enc_pkg::out_item_t result;
    logic                   res_valid;
    logic                   res_stall = 1'b0;

    int          idle_pct = 0;
    int          stall_pct = 0;
    int          items_sent = 0;
    int unsigned quiet_cycles = 0;
    entry_scoreboard sb = new();

    mib_entry_encoder_top u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .result     (result),
        .res_valid  (res_valid),
        .res_stall  (res_stall)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        res_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);

    // Both sides are sampled in one process so the expectation always exists first.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && !item_stall)
                sb.note_item(item);
            if (res_valid && !res_stall)
                sb.check_result(result);
        end
    end

    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (res_valid && !res_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic void set_idling(int phase);
        case (phase)
            0:
            begin
                idle_pct  = 0;
                stall_pct = 0;
            end
            1:
            begin
                idle_pct  = 60;
                stall_pct = 0;
            end
            2:
            begin
                idle_pct  = 0;
                stall_pct = 60;
            end
            default:
            begin
                idle_pct  = 6;
                stall_pct = 6;
            end
        endcase
    endfunction

    task automatic send_item(input mib_enc_pkg::in_item_t it);
        set_idling((items_sent / PHASE_ITEMS) % 4);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        items_sent++;
    endtask

    function automatic mib_enc_pkg::in_item_t header_item(logic [15:0] id, logic [15:0] a,
                                                          logic [15:0] b, logic [2:0] kind,
                                                          logic [31:0] word,
                                                          logic [10:0] count);
        mib_enc_pkg::in_item_t it;
        it.action       = mib_enc_pkg::ACTION_HEADER;
        it.param_id     = id;
        it.index_a      = a;
        it.index_b      = b;
        it.value_kind   = kind;
        it.value_word   = word;
        it.octet_count  = count;
        it.payload_byte = 8'($urandom);
        return it;
    endfunction

    // Header fields of a payload transfer are noise; the block must ignore them.
    function automatic mib_enc_pkg::in_item_t payload_item(logic [7:0] data);
        mib_enc_pkg::in_item_t it;
        it              = mib_enc_pkg::in_item_t'($bits(mib_enc_pkg::in_item_t)'(
                              {$urandom, $urandom, $urandom, $urandom}));
        it.action       = mib_enc_pkg::ACTION_PAYLOAD;
        it.payload_byte = data;
        return it;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0:       return $urandom_range(63);
            1:       return $urandom_range(255);
            2:       return $urandom_range(65535);
            3:       return $urandom_range(32'h00FF_FFFF);
            4:       return $urandom;
            default: return ~($urandom >> $urandom_range(1, 31));
        endcase
    endfunction

    function automatic logic [15:0] rand_index();
        case ($urandom_range(4))
            0:       return 16'h0000;
            1:       return 16'($urandom_range(1, 63));
            2:       return 16'($urandom_range(64, 255));
            3:       return 16'($urandom_range(256, 65535));
            default: return 16'hFFFF;
        endcase
    endfunction

    function automatic mib_enc_pkg::in_item_t random_header();
        int          r;
        logic [2:0]  kind;
        logic [10:0] count;
        r = $urandom_range(99);
        if (r < 10)
            kind = 3'($urandom_range(KIND_BAD_FIRST, KIND_BAD_LAST));
        else if (r < 35)
            kind = mib_enc_pkg::KIND_OCTETS;
        else
            kind = 3'($urandom_range(mib_enc_pkg::KIND_NONE, mib_enc_pkg::KIND_BOOLEAN));
        count = 11'($urandom_range(2047));
        if (kind == mib_enc_pkg::KIND_OCTETS)
        begin
            r = $urandom_range(99);
            if (r < 85)
                count = 11'($urandom_range(12));
            else if (r < 95)
                count = 11'($urandom_range(13, 40));
            else if (r < 98)
                count = 11'($urandom_range(41, 255));
            else
                count = 11'($urandom_range(256, 2047));
        end
        return header_item(16'($urandom), rand_index(), rand_index(), kind, rand_word(), count);
    endfunction

    task automatic run_directed();
        send_item(header_item(16'h0000, 16'h0000, 16'h0000, mib_enc_pkg::KIND_NONE,
                              32'h0, 11'd0));
        send_item(header_item(16'hFFFF, 16'd63, 16'd64, mib_enc_pkg::KIND_UNSIGNED,
                              32'hFFFF_FFFF, 11'd0));
        send_item(header_item(16'h1234, 16'hFFFF, 16'hFFFF, mib_enc_pkg::KIND_UNSIGNED,
                              32'h0, 11'd5));
        // The index list stops at a zero first index even if the second is set.
        send_item(header_item(16'h00A5, 16'h0000, 16'd5, mib_enc_pkg::KIND_SIGNED,
                              32'hFFFF_FFFF, 11'd0));
        send_item(header_item(16'h0101, 16'd300, 16'h0000, mib_enc_pkg::KIND_SIGNED,
                              32'hFFFF_FFC0, 11'd0));
        send_item(header_item(16'h0202, 16'd1, 16'd2, mib_enc_pkg::KIND_SIGNED,
                              32'hFFFF_FFBF, 11'd0));
        send_item(header_item(16'h0303, 16'd7, 16'h0000, mib_enc_pkg::KIND_SIGNED,
                              32'h8000_0000, 11'd0));
        send_item(header_item(16'h0404, 16'd70, 16'd9, mib_enc_pkg::KIND_SIGNED,
                              32'hFFFF_8000, 11'd0));
        send_item(header_item(16'h0505, 16'd1000, 16'd1, mib_enc_pkg::KIND_SIGNED,
                              32'hFFFF_7FFF, 11'd0));
        // Bit 28 alone is a positive value and must not be taken as a sign.
        send_item(header_item(16'h0606, 16'd3, 16'd4, mib_enc_pkg::KIND_SIGNED,
                              32'h1000_0000, 11'd0));
        send_item(header_item(16'h0707, 16'd0, 16'd0, mib_enc_pkg::KIND_SIGNED,
                              32'h7FFF_FFFF, 11'd0));
        send_item(header_item(16'h0808, 16'd12, 16'd0, mib_enc_pkg::KIND_BOOLEAN,
                              32'h0, 11'd0));
        send_item(header_item(16'h0909, 16'd65, 16'd66, mib_enc_pkg::KIND_BOOLEAN,
                              32'h8000_0000, 11'd0));
        send_item(header_item(16'h0A0A, 16'd1, 16'd1, KIND_BAD_FIRST, 32'h1, 11'd0));
        send_item(header_item(16'h0B0B, 16'd1, 16'd1, KIND_BAD_LAST, 32'h1, 11'd3));
        send_item(payload_item(8'hFF));
        send_item(header_item(16'h0C0C, 16'd2, 16'd0, mib_enc_pkg::KIND_OCTETS,
                              32'h0, 11'd0));
        send_item(header_item(16'h0D0D, 16'd2, 16'd0, mib_enc_pkg::KIND_OCTETS,
                              32'h0, 11'd3));
        send_item(payload_item(8'h00));
        send_item(payload_item(8'hFF));
        send_item(payload_item(8'h5A));
        // An oversized count saturates; the string is then cut short by a new header.
        send_item(header_item(16'h0E0E, 16'd0, 16'd0, mib_enc_pkg::KIND_OCTETS,
                              32'h0, 11'd2047));
        send_item(payload_item(8'h11));
        send_item(payload_item(8'h22));
        send_item(header_item(16'h0F0F, 16'd64, 16'd0, mib_enc_pkg::KIND_OCTETS,
                              32'h0, 11'd1));
        send_item(payload_item(8'h33));
    endtask

    task automatic run_random();
        int                    stop_at;
        int                    n;
        logic [10:0]           cnt;
        mib_enc_pkg::in_item_t h;
        stop_at = items_sent + RANDOM_ITEMS;
        while (items_sent < stop_at)
        begin
            h = random_header();
            send_item(h);
            if (h.value_kind == mib_enc_pkg::KIND_OCTETS)
            begin
                cnt = (h.octet_count > mib_enc_pkg::MAX_OCTETS)
                      ? 11'(mib_enc_pkg::MAX_OCTETS) : h.octet_count;
                n   = int'(cnt);
                // Long strings are cut short by the next header to keep the run brief, and shorter ones sometimes too.
                if (cnt > 11'd255)
                    n = $urandom_range(8);
                else if ($urandom_range(99) < 12)
                    n = $urandom_range(cnt);
                repeat (n)
                    send_item(payload_item(8'($urandom)));
            end
            if ($urandom_range(99) < 8)
                send_item(payload_item(8'($urandom)));
        end
    endtask

    initial
    begin
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random();
        item_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: files.f
rtl/core/mib_enc_pkg.sv
rtl/core/mib_enc_format.sv
rtl/core/mib_enc_emit.sv
rtl/core/mib_entry_encoder_top.sv
rtl/core/mib_enc_checker.sv
sim/mib_entry_encoder_top_tb.sv
